// ===== hdl/cvsf_pkg.sv =====
// shared types, widths and codes for the window cv stability filter
`timescale 1ns / 1ps
package cvsf_pkg;

    localparam int DATA_W         = 14;
    localparam int WIN_W          = 5;
    localparam int LIM_W          = 7;
    localparam int CFG_W          = 14;
    localparam int IDX_W          = 2;
    localparam int STATUS_W       = 2;
    localparam int MAX_WINDOW_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CV_SCALE       = 10000;
    localparam int CV_SCALE_W     = 14;

    localparam logic [WIN_W-1:0]         WINDOW_RST   = 5'd10;
    localparam logic [LIM_W-1:0]         LIMIT_RST    = 7'd10;
    localparam logic signed [DATA_W-1:0] FALLBACK_RST = 14'sd2500;

    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW   = 2'd0,
        REG_LIMIT    = 2'd1,
        REG_FALLBACK = 2'd2
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_STABLE     = 2'd0,
        ST_CKPT       = 2'd1,
        ST_NONE       = 2'd2,
        ST_INCOMPLETE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_SUBST  = 2'd1,
        OP_EVAL   = 2'd2
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic signed [DATA_W-1:0]  temperature;
    } t_req;

endpackage

// ===== hdl/cvsf_if.sv =====
// request, result and configuration channel interfaces
`timescale 1ns / 1ps
interface cvsf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic signed [cvsf_pkg::DATA_W-1:0]   temperature;
    logic                                 sensor_ok;

    modport source (output valid, output command, output temperature, output sensor_ok,
                    input ready);
    modport sink (input valid, input command, input temperature, input sensor_ok,
                  output ready);
endinterface

interface cvsf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [cvsf_pkg::STATUS_W-1:0]        status;
    logic signed [cvsf_pkg::DATA_W-1:0]   published_value;
    logic signed [cvsf_pkg::DATA_W-1:0]   window_mean;

    modport source (output valid, output status, output published_value,
                    output window_mean, input ready);
    modport sink (input valid, input status, input published_value,
                  input window_mean, output ready);
endinterface

interface cvsf_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [cvsf_pkg::IDX_W-1:0]           index;
    logic [cvsf_pkg::CFG_W-1:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/window_cv_stability_filter_unit.sv =====
// top level of the window cv stability filter
`timescale 1ns / 1ps
// Temperature samples (hundredths of a degree) and evaluate requests enter a two-entry
// queue at up to one per cycle while it has room; the back end drains it. A sample
// request occupies the back end while it is squared on the shared multiplier and then
// accumulated; a sample arriving at a full window is dropped. An evaluate request is
// paced by the bit-serial divider that forms the window mean; the variance test runs on
// the shared multiplier in parallel with it. An evaluate waits for the result register
// to be free. Configuration writes are accepted every cycle and must be issued only
// while the block is idle.
module window_cv_stability_filter_unit #(
    parameter int MAX_WINDOW = cvsf_pkg::MAX_WINDOW_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cvsf_in_if.sink      i_in,
    cvsf_out_if.source   o_out,
    cvsf_cfg_if.sink     i_cfg
);

    logic            w_q_valid;
    cvsf_pkg::t_req  w_q_head;
    logic            w_q_pop;

    cvsf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .o_q_head  (w_q_head),
        .i_q_pop   (w_q_pop)
    );

    cvsf_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_head  (w_q_head),
        .o_q_pop   (w_q_pop),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

endmodule

// ===== hdl/cvsf_front.sv =====
// front end: request intake, classification and the request queue
`timescale 1ns / 1ps
module cvsf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cvsf_in_if.sink         i_in,
    output logic            o_q_valid,
    output cvsf_pkg::t_req  o_q_head,
    input  logic            i_q_pop
);

    localparam int DEPTH = cvsf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cvsf_pkg::t_req    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    cvsf_pkg::t_req    w_req;
    logic              w_push;
    logic              w_pop;

    // classify the request
    always_comb begin
        w_req.temperature = i_in.temperature;
        if (i_in.command) begin
            w_req.op = cvsf_pkg::OP_EVAL;
        end else if (i_in.sensor_ok) begin
            w_req.op = cvsf_pkg::OP_SAMPLE;
        end else begin
            w_req.op = cvsf_pkg::OP_SUBST;
        end
    end

    assign i_in.ready = (r_count != CNT_W'(DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_q_pop && (r_count != '0);
    assign o_q_valid  = (r_count != '0);
    assign o_q_head   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_req;
        end
    end

endmodule

// ===== hdl/cvsf_mul.sv =====
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps
module cvsf_mul #(
    parameter int A_W = 36,
    parameter int B_W = 18
) (
    input  logic                 i_clk,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic [A_W+B_W-1:0]   o_p
);

    logic [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_p = r_prod;

endmodule

// ===== hdl/cvsf_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module cvsf_div #(
    parameter int N_W = 18,
    parameter int D_W = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [N_W-1:0]  i_dividend,
    input  logic [D_W-1:0]  i_divisor,
    output logic            o_busy,
    output logic [N_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]    r_quo;
    logic [D_W-1:0]    r_rem;
    logic [D_W-1:0]    r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [D_W:0]      w_shift;
    logic [D_W:0]      w_diff;
    logic              w_ge;

    assign w_shift = {r_rem, r_quo[N_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[N_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_shift[D_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/cvsf_back.sv =====
// back end: window accumulation, stability test, checkpoint and result register
`timescale 1ns / 1ps
module cvsf_back #(
    parameter int MAX_WINDOW = cvsf_pkg::MAX_WINDOW_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  cvsf_pkg::t_req  i_q_head,
    output logic            o_q_pop,
    cvsf_cfg_if.sink        i_cfg,
    cvsf_out_if.source      o_out
);

    localparam int DATA_W = cvsf_pkg::DATA_W;
    localparam int LIM_W  = cvsf_pkg::LIM_W;
    localparam int CW     = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = DATA_W + $clog2(MAX_WINDOW);
    localparam int SQ_W   = 2 * DATA_W - 1 + $clog2(MAX_WINDOW);
    localparam int WIDE_W = SQ_W + CW;
    localparam int A_W    = WIDE_W;
    localparam int B_W    = (SUM_W > cvsf_pkg::CV_SCALE_W) ? SUM_W : cvsf_pkg::CV_SCALE_W;
    localparam int P_W    = A_W + B_W;
    localparam int CMP_W  = WIDE_W + cvsf_pkg::CV_SCALE_W;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_SMP_MUL = 11'b000_0000_0010,
        S_SMP_ACC = 11'b000_0000_0100,
        S_E_SQ    = 11'b000_0000_1000,
        S_E_NQ    = 11'b000_0001_0000,
        S_E_TT    = 11'b000_0010_0000,
        S_E_SUB   = 11'b000_0100_0000,
        S_E_LHS   = 11'b000_1000_0000,
        S_E_RHS   = 11'b001_0000_0000,
        S_E_RES   = 11'b010_0000_0000,
        S_E_DONE  = 11'b100_0000_0000
    } t_state;

    t_state                         r_state, n_state;
    logic [cvsf_pkg::WIN_W-1:0]     r_window;
    logic [LIM_W-1:0]               r_limit;
    logic signed [DATA_W-1:0]       r_fallback;
    logic signed [SUM_W-1:0]        r_sum;
    logic [SQ_W-1:0]                r_sq;
    logic [CW-1:0]                  r_count;
    logic signed [DATA_W-1:0]       r_ckpt;
    logic                           r_ckpt_valid;
    logic signed [DATA_W-1:0]       r_v;
    logic [WIDE_W-1:0]              r_s2;
    logic [WIDE_W-1:0]              r_nq;
    logic [WIDE_W-1:0]              r_spread;
    logic [2*LIM_W-1:0]             r_t2;
    logic [CMP_W-1:0]               r_lhs;
    logic [CMP_W-1:0]               r_rhs;
    logic                           r_out_valid;
    cvsf_pkg::t_status              r_status;
    logic signed [DATA_W-1:0]       r_pub;
    logic signed [DATA_W-1:0]       r_mean;

    logic [CW-1:0]                  w_n;
    logic signed [DATA_W-1:0]       w_sub;
    logic [DATA_W-1:0]              w_v_mag;
    logic [SUM_W-1:0]               w_sum_mag;
    logic [A_W-1:0]                 w_mul_a;
    logic [B_W-1:0]                 w_mul_b;
    logic [P_W-1:0]                 w_mul_p;
    logic                           w_div_start;
    logic                           w_div_busy;
    logic [SUM_W-1:0]               w_div_quo;
    logic [DATA_W-1:0]              w_quo_t;
    logic signed [DATA_W-1:0]       w_mean;
    logic                           w_in_room;
    logic                           w_full;
    logic                           w_pos;
    logic                           w_unstable;
    logic                           w_finish;

    // effective window size
    always_comb begin
        if (r_window == '0) begin
            w_n = CW'(1);
        end else if (int'(r_window) > MAX_WINDOW) begin
            w_n = CW'(MAX_WINDOW);
        end else begin
            w_n = CW'(r_window);
        end
    end

    assign w_sub       = r_ckpt_valid ? r_ckpt : r_fallback;
    assign w_v_mag     = r_v[DATA_W-1] ? (~r_v + 1'b1) : r_v;
    assign w_sum_mag   = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign w_in_room   = (r_count < w_n);
    assign w_full      = (r_count == w_n);
    assign w_pos       = !r_sum[SUM_W-1] && (r_sum != '0);
    assign w_unstable  = w_pos && (r_lhs > r_rhs);
    assign w_quo_t     = w_div_quo[DATA_W-1:0];
    assign w_mean      = r_sum[SUM_W-1] ? DATA_W'(~w_quo_t + 1'b1) : w_quo_t;
    assign w_finish    = (r_state == S_E_DONE) && !w_div_busy;

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid
                         && ((i_q_head.op != cvsf_pkg::OP_EVAL) || !r_out_valid);
    assign w_div_start = o_q_pop && (i_q_head.op == cvsf_pkg::OP_EVAL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    unique case (i_q_head.op) inside
                        cvsf_pkg::OP_SAMPLE, cvsf_pkg::OP_SUBST: begin
                            if (w_in_room) begin
                                n_state = S_SMP_MUL;
                            end
                        end
                        cvsf_pkg::OP_EVAL: n_state = S_E_SQ;
                        default: ;
                    endcase
                end
            end
            S_SMP_MUL: n_state = S_SMP_ACC;
            S_SMP_ACC: n_state = S_IDLE;
            S_E_SQ:    n_state = S_E_NQ;
            S_E_NQ:    n_state = S_E_TT;
            S_E_TT:    n_state = S_E_SUB;
            S_E_SUB:   n_state = S_E_LHS;
            S_E_LHS:   n_state = S_E_RHS;
            S_E_RHS:   n_state = S_E_RES;
            S_E_RES:   n_state = S_E_DONE;
            S_E_DONE: begin
                if (!w_div_busy) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_SMP_MUL: begin
                w_mul_a = A_W'(w_v_mag);
                w_mul_b = B_W'(w_v_mag);
            end
            S_E_SQ: begin
                w_mul_a = A_W'(w_sum_mag);
                w_mul_b = B_W'(w_sum_mag);
            end
            S_E_NQ: begin
                w_mul_a = A_W'(r_sq);
                w_mul_b = B_W'(w_n);
            end
            S_E_TT: begin
                w_mul_a = A_W'(r_limit);
                w_mul_b = B_W'(r_limit);
            end
            S_E_LHS: begin
                w_mul_a = r_spread;
                w_mul_b = B_W'(cvsf_pkg::CV_SCALE);
            end
            S_E_RHS: begin
                w_mul_a = r_s2;
                w_mul_b = B_W'(r_t2);
            end
            default: ;
        endcase
    end

    cvsf_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    cvsf_div #(
        .N_W (SUM_W),
        .D_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum_mag),
        .i_divisor  (w_n),
        .o_busy     (w_div_busy),
        .o_quotient (w_div_quo)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window     <= cvsf_pkg::WINDOW_RST;
            r_limit      <= cvsf_pkg::LIMIT_RST;
            r_fallback   <= cvsf_pkg::FALLBACK_RST;
            r_sum        <= '0;
            r_sq         <= '0;
            r_count      <= '0;
            r_ckpt       <= '0;
            r_ckpt_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    cvsf_pkg::REG_WINDOW:   r_window   <= i_cfg.data[cvsf_pkg::WIN_W-1:0];
                    cvsf_pkg::REG_LIMIT:    r_limit    <= i_cfg.data[LIM_W-1:0];
                    cvsf_pkg::REG_FALLBACK: r_fallback <= $signed(i_cfg.data);
                    default: ;
                endcase
            end
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_SMP_MUL) begin
                r_sum   <= r_sum + SUM_W'(r_v);
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_SMP_ACC) begin
                r_sq <= r_sq + SQ_W'(w_mul_p[2*DATA_W-1:0]);
            end
            if (w_finish) begin
                r_sum       <= '0;
                r_sq        <= '0;
                r_count     <= '0;
                r_out_valid <= 1'b1;
                if (w_full && !w_unstable) begin
                    r_ckpt       <= w_mean;
                    r_ckpt_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_v <= (i_q_head.op == cvsf_pkg::OP_SAMPLE) ? i_q_head.temperature : w_sub;
        end
        unique case (r_state)
            S_E_NQ:  r_s2 <= w_mul_p[WIDE_W-1:0];
            S_E_TT:  r_nq <= w_mul_p[WIDE_W-1:0];
            S_E_SUB: begin
                r_t2     <= w_mul_p[2*LIM_W-1:0];
                r_spread <= r_nq - r_s2;
            end
            S_E_RHS: r_lhs <= w_mul_p[CMP_W-1:0];
            S_E_RES: r_rhs <= w_mul_p[CMP_W-1:0];
            default: ;
        endcase
        if (w_finish) begin
            if (!w_full) begin
                r_status <= cvsf_pkg::ST_INCOMPLETE;
                r_pub    <= '0;
                r_mean   <= '0;
            end else if (!w_unstable) begin
                r_status <= cvsf_pkg::ST_STABLE;
                r_pub    <= w_mean;
                r_mean   <= w_mean;
            end else if (r_ckpt_valid) begin
                r_status <= cvsf_pkg::ST_CKPT;
                r_pub    <= r_ckpt;
                r_mean   <= w_mean;
            end else begin
                r_status <= cvsf_pkg::ST_NONE;
                r_pub    <= '0;
                r_mean   <= w_mean;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.published_value = r_pub;
    assign o_out.window_mean     = r_mean;

endmodule

// ===== hdl/cvsf_chk.sv =====
// port-level checker for the window cv stability filter, bound to the top level
`timescale 1ns / 1ps
module cvsf_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic [cvsf_pkg::STATUS_W-1:0]        i_status,
    input logic signed [cvsf_pkg::DATA_W-1:0]   i_pub,
    input logic signed [cvsf_pkg::DATA_W-1:0]   i_mean
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_pub) && $stable(i_mean))
        else $error("result changed while stalled");

    a_blank_pub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == cvsf_pkg::ST_NONE || i_status == cvsf_pkg::ST_INCOMPLETE)
            |-> i_pub == '0)
        else $error("published value not cleared when nothing published");

    a_blank_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == cvsf_pkg::ST_INCOMPLETE |-> i_mean == '0)
        else $error("mean not cleared for incomplete window");

    a_stable_pub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == cvsf_pkg::ST_STABLE |-> i_pub == i_mean)
        else $error("stable window published something other than its mean");

endmodule

bind window_cv_stability_filter_unit cvsf_chk u_cvsf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_pub       (o_out.published_value),
    .i_mean      (o_out.window_mean)
);
